FILE: sv/cors_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the circular-orbit redshift pipeline.
// No dependencies; imported by every module of the block.
package cors_pkg;

	localparam int FRAC_BITS = 24;
	localparam int OUT_FRAC  = 28;
	localparam int IN_W      = 32;
	localparam int SPIN_W    = 26;
	localparam int OUT_W     = 32;

	// Square-root unit: one frame wide enough for the radicand.
	localparam int SQ_IN_W   = 74;
	localparam int SQ_OUT_W  = SQ_IN_W / 2;
	localparam int SQ_REM_W  = SQ_OUT_W + 2;
	localparam int SQ_SIDE_W = IN_W + SPIN_W + IN_W;

	// Divider: positive denominator and quotient integer bits.
	localparam int D_W       = 37;
	localparam int DIV_REM_W = D_W + 1;
	localparam int INT_W     = OUT_W - OUT_FRAC;

	typedef struct packed {
		logic no_emitter;
		logic saturated;
	} cors_flags_t;

endpackage

FILE: sv/cors_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on cors_pkg.
module cors_sqrt import cors_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic [SQ_IN_W-1:0]   in_x,
	input  logic [SQ_SIDE_W-1:0] in_side,
	output logic                 out_vld,
	output logic [SQ_OUT_W-1:0]  out_root,
	output logic [SQ_SIDE_W-1:0] out_side
);

	typedef struct packed {
		logic [SQ_IN_W-1:0]  x;
		logic [SQ_REM_W-1:0] rem;
		logic [SQ_OUT_W-1:0] root;
	} sq_stage_t;

	function automatic sq_stage_t sq_step(input sq_stage_t c);
		sq_stage_t n;
		logic [SQ_REM_W-1:0] rs;
		logic [SQ_REM_W-1:0] tr;
		rs = {c.rem[SQ_REM_W-3:0], c.x[SQ_IN_W-1 -: 2]};
		tr = {c.root, 2'b01};
		n.x = {c.x[SQ_IN_W-3:0], 2'b00};
		if (rs >= tr) begin
			n.rem  = rs - tr;
			n.root = {c.root[SQ_OUT_W-2:0], 1'b1};
		end else begin
			n.rem  = rs;
			n.root = {c.root[SQ_OUT_W-2:0], 1'b0};
		end
		return n;
	endfunction

	sq_stage_t              st_s   [1:SQ_OUT_W];
	logic [SQ_SIDE_W-1:0]   side_s [1:SQ_OUT_W];
	logic [SQ_OUT_W:1]      vld_s;
	sq_stage_t              init;

	assign init.x    = in_x;
	assign init.rem  = '0;
	assign init.root = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[SQ_OUT_W-1:1], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[1]   <= sq_step(init);
			side_s[1] <= in_side;
			for (int k = 2; k <= SQ_OUT_W; k++) begin
				st_s[k]   <= sq_step(st_s[k-1]);
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_vld  = vld_s[SQ_OUT_W];
	assign out_root = st_s[SQ_OUT_W].root;
	assign out_side = side_s[SQ_OUT_W];

endmodule

FILE: sv/cors_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider S * 2^OUT_FRAC / D, one quotient bit per stage,
// with the overflow test at entry. Depends on cors_pkg.
module cors_div import cors_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  logic [SQ_OUT_W-1:0] in_s,
	input  logic [D_W-1:0]      in_d,
	input  logic                in_ne,
	output logic                out_vld,
	output logic [OUT_W-1:0]    out_q,
	output cors_flags_t         out_flags
);

	typedef struct packed {
		logic [DIV_REM_W-1:0] rem;
		logic [D_W-1:0]       d;
		logic [OUT_W-1:0]     n;
		logic [OUT_W-1:0]     q;
	} dv_stage_t;

	function automatic dv_stage_t dv_step(input dv_stage_t c);
		dv_stage_t o;
		logic [DIV_REM_W-1:0] rs;
		rs = {c.rem[DIV_REM_W-2:0], c.n[OUT_W-1]};
		o.d = c.d;
		o.n = {c.n[OUT_W-2:0], 1'b0};
		if (rs >= {1'b0, c.d}) begin
			o.rem = rs - {1'b0, c.d};
			o.q   = {c.q[OUT_W-2:0], 1'b1};
		end else begin
			o.rem = rs;
			o.q   = {c.q[OUT_W-2:0], 1'b0};
		end
		return o;
	endfunction

	dv_stage_t   st_s  [1:OUT_W];
	cors_flags_t flg_s [1:OUT_W];
	logic [OUT_W:1] vld_s;
	dv_stage_t   init;
	cors_flags_t init_flg;
	logic        bypass;

	// Quotient of 16 or more cannot be represented: flag and skip the division.
	assign init_flg.no_emitter = in_ne;
	assign init_flg.saturated  = !in_ne &&
		({{INT_W{1'b0}}, in_s} >= {in_d, {INT_W{1'b0}}});
	assign bypass   = in_ne || init_flg.saturated;
	assign init.d   = bypass ? D_W'(1) : in_d;
	assign init.rem = bypass ? '0 : DIV_REM_W'(in_s >> INT_W);
	assign init.n   = bypass ? '0 : {in_s[INT_W-1:0], {OUT_FRAC{1'b0}}};
	assign init.q   = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[OUT_W-1:1], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[1]  <= dv_step(init);
			flg_s[1] <= init_flg;
			for (int k = 2; k <= OUT_W; k++) begin
				st_s[k]  <= dv_step(st_s[k-1]);
				flg_s[k] <= flg_s[k-1];
			end
		end
	end

	assign out_vld   = vld_s[OUT_W];
	assign out_q     = st_s[OUT_W].q;
	assign out_flags = flg_s[OUT_W];

endmodule

FILE: sv/circular_orbit_redshift_factor.sv
`timescale 1ns / 1ps
// Redshift factor of a circular-orbit emitter, fully pipelined.
// From request accept to result valid: 37 sqrt(r) stages,
// 5 polynomial stages, 37 sqrt(radicand) stages, 32 divider stages, 1 output.
// Throughput: one request per cycle; a held result stalls the whole pipe.
// Reset (arst_n low, asynchronous): all valid bits clear, spin returns to 0.
module circular_orbit_redshift_factor import cors_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic signed [SPIN_W-1:0] cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [IN_W-1:0]          radius,
	input  logic signed [IN_W-1:0]   impact_param,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [OUT_W-1:0]         redshift,
	output logic                     no_emitter,
	output logic                     saturated
);

	localparam int S1_W   = (IN_W + FRAC_BITS) / 2;       // width of sqrt(r)
	localparam int RS_W   = IN_W + S1_W;                  // r * sqrt(r)
	localparam int P_W    = RS_W - FRAC_BITS;             // r^1.5
	localparam int R2_W   = 2 * IN_W;                     // r^2
	localparam int AP_W   = SPIN_W + 1 + P_W;             // 2|a| * r^1.5
	localparam int C_W    = R2_W + IN_W;                  // r^3 before scaling
	localparam int CUBE_W = C_W - FRAC_BITS;
	localparam int N3_W   = R2_W + 2;                     // 3 r^2
	localparam int POS_W  = CUBE_W + 1;
	localparam int NEG_W  = N3_W + 1;
	localparam int DIF_W  = SQ_IN_W + 1;
	localparam int DS_W   = D_W + 2;                      // signed denominator

	logic adv;
	logic signed [SPIN_W-1:0] spin_q;

	// Global stall: the pipe moves unless a finished result is being held.
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spin_q <= '0;
		end else if (cfg_we) begin
			spin_q <= cfg_wdata;
		end
	end

	// sqrt(r): radius scaled by 2^FRAC_BITS, spin and b ride along.
	logic                 sq1_vld;
	logic [SQ_OUT_W-1:0]  sq1_root;
	logic [SQ_SIDE_W-1:0] sq1_side;

	cors_sqrt u_sqrt_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (in_valid),
		.in_x     (SQ_IN_W'({radius, {FRAC_BITS{1'b0}}})),
		.in_side  ({radius, spin_q, impact_param}),
		.out_vld  (sq1_vld),
		.out_root (sq1_root),
		.out_side (sq1_side)
	);

	logic [IN_W-1:0]          r_u;
	logic signed [SPIN_W-1:0] a_u;
	logic signed [IN_W-1:0]   b_u;

	assign r_u = sq1_side[SQ_SIDE_W-1 -: IN_W];
	assign a_u = sq1_side[IN_W +: SPIN_W];
	assign b_u = sq1_side[IN_W-1:0];

	// Stage 1: r*sqrt(r) and r^2.
	logic                     v_s1;
	logic [RS_W-1:0]          rs_s1;
	logic [R2_W-1:0]          r2_s1;
	logic [IN_W-1:0]          r_s1;
	logic signed [SPIN_W-1:0] a_s1;
	logic signed [IN_W-1:0]   b_s1;

	// Stage 2: r^3 partial products, 3r^2, 2|a|r^1.5, denominator.
	logic                     v_s2;
	logic [R2_W-1:0]          clo_s2;
	logic [R2_W-1:0]          chi_s2;
	logic [N3_W-1:0]          n3_s2;
	logic [AP_W-1:0]          ap_s2;
	logic                     aneg_s2;
	logic signed [DS_W-1:0]   d_s2;

	// Stage 3: r^3 scaled back.
	logic                     v_s3;
	logic [CUBE_W-1:0]        cube_s3;
	logic [N3_W-1:0]          n3_s3;
	logic [AP_W-1:0]          ap_s3;
	logic                     aneg_s3;
	logic signed [DS_W-1:0]   d_s3;

	// Stage 4: positive and negative halves of the radicand.
	logic                     v_s4;
	logic [POS_W-1:0]         pos_s4;
	logic [NEG_W-1:0]         neg_s4;
	logic signed [DS_W-1:0]   d_s4;

	// Stage 5: radicand and the no-emitter decision.
	logic                     v_s5;
	logic [SQ_IN_W-1:0]       rad_s5;
	logic                     ne_s5;
	logic [D_W-1:0]           d_s5;

	logic [P_W-1:0]    p_w;
	logic [SPIN_W-1:0] abs_a;
	logic [C_W-1:0]    cube_full;
	logic [DIF_W-1:0]  diff;

	assign p_w       = rs_s1[RS_W-1:FRAC_BITS];
	assign abs_a     = a_s1[SPIN_W-1] ? SPIN_W'(-a_s1) : a_s1;
	assign cube_full = (C_W'(chi_s2) << IN_W) + C_W'(clo_s2);
	assign diff      = DIF_W'(pos_s4) - DIF_W'(neg_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= sq1_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rs_s1   <= RS_W'(r_u) * RS_W'(sq1_root[S1_W-1:0]);
			r2_s1   <= R2_W'(r_u) * R2_W'(r_u);
			r_s1    <= r_u;
			a_s1    <= a_u;
			b_s1    <= b_u;

			clo_s2  <= R2_W'(r2_s1[IN_W-1:0]) * R2_W'(r_s1);
			chi_s2  <= R2_W'(r2_s1[R2_W-1:IN_W]) * R2_W'(r_s1);
			n3_s2   <= N3_W'({r2_s1, 1'b0}) + N3_W'(r2_s1);
			ap_s2   <= AP_W'({abs_a, 1'b0}) * AP_W'(p_w);
			aneg_s2 <= a_s1[SPIN_W-1];
			d_s2    <= DS_W'($signed({1'b0, p_w})) + DS_W'(a_s1) - DS_W'(b_s1);

			cube_s3 <= cube_full[C_W-1:FRAC_BITS];
			n3_s3   <= n3_s2;
			ap_s3   <= ap_s2;
			aneg_s3 <= aneg_s2;
			d_s3    <= d_s2;

			// Spin term joins whichever side matches its sign.
			pos_s4  <= POS_W'(cube_s3) + (aneg_s3 ? '0 : POS_W'(ap_s3));
			neg_s4  <= NEG_W'(n3_s3) + (aneg_s3 ? NEG_W'(ap_s3) : '0);
			d_s4    <= d_s3;

			rad_s5  <= diff[SQ_IN_W-1:0];
			ne_s5   <= diff[DIF_W-1] || (diff == '0) ||
				d_s4[DS_W-1] || (d_s4 == '0);
			d_s5    <= d_s4[D_W-1:0];
		end
	end

	// sqrt(radicand): drop the radicand to zero for a rejected request.
	logic                 sq2_vld;
	logic [SQ_OUT_W-1:0]  sq2_root;
	logic [SQ_SIDE_W-1:0] sq2_side;

	cors_sqrt u_sqrt_rad (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (v_s5),
		.in_x     (ne_s5 ? '0 : rad_s5),
		.in_side  (SQ_SIDE_W'({d_s5, ne_s5})),
		.out_vld  (sq2_vld),
		.out_root (sq2_root),
		.out_side (sq2_side)
	);

	logic        dv_vld;
	logic [OUT_W-1:0] dv_q;
	cors_flags_t dv_flags;

	cors_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_vld    (sq2_vld),
		.in_s      (sq2_root),
		.in_d      (sq2_side[D_W:1]),
		.in_ne     (sq2_side[0]),
		.out_vld   (dv_vld),
		.out_q     (dv_q),
		.out_flags (dv_flags)
	);

	// Output register: hold the result until the consumer takes it.
	logic             out_valid_q;
	logic [OUT_W-1:0] redshift_q;
	cors_flags_t      flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_q <= dv_flags;
			if (dv_flags.no_emitter) begin
				redshift_q <= '0;
			end else if (dv_flags.saturated) begin
				redshift_q <= '1;
			end else begin
				redshift_q <= dv_q;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign redshift   = redshift_q;
	assign no_emitter = flags_q.no_emitter;
	assign saturated  = flags_q.saturated;

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(no_emitter && saturated))
		else $error("no_emitter and saturated raised together");

	a_no_emitter_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && no_emitter) |-> (redshift == '0))
		else $error("no-emitter result not zero");

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled with no held result");

endmodule
